/* src/kfs_pkg.sv */
package kfs_pkg;

  // fixed payload widths
  localparam int unsigned NameW  = 64;
  localparam int unsigned AgeW   = 8;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned NameCh = NameW / ByteW;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_SEARCH  = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_FOUND    = 3'd5,
    ST_NOTFOUND = 3'd6
  } status_e;

endpackage

/* src/kfs_store.sv */
module kfs_store import kfs_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [NameW-1:0] wname_i,
  input  logic [AgeW-1:0]  wage_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [NameW-1:0] rname_o,
  output logic [AgeW-1:0]  rage_o
);

  logic [NameW-1:0] name_mem [DEPTH];
  logic [AgeW-1:0]  age_mem  [DEPTH];
  logic [NameW-1:0] rname_q;
  logic [AgeW-1:0]  rage_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      name_mem[waddr_i] <= wname_i;
      age_mem[waddr_i]  <= wage_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rname_q <= name_mem[raddr_i];
      rage_q  <= age_mem[raddr_i];
    end
  end

  assign rname_o = rname_q;
  assign rage_o  = rage_q;

endmodule

/* src/kfs_match.sv */
module kfs_match import kfs_pkg::*; (
  input  logic [NameW-1:0] key_i,
  input  logic [NameW-1:0] entry_i,
  input  logic             fold_i,
  output logic             hit_o
);

  // map ascii upper case to lower case, byte by byte
  function automatic logic [NameW-1:0] fold_case(input logic [NameW-1:0] v);
    logic [NameW-1:0] res;
    logic [ByteW-1:0] b;
    res = v;
    for (int i = 0; i < NameCh; i++) begin
      b = v[i*ByteW +: ByteW];
      if (b >= 8'h41 && b <= 8'h5a) begin
        res[i*ByteW +: ByteW] = b + 8'h20;
      end
    end
    return res;
  endfunction

  logic [NameW-1:0] key_cmp;
  logic [NameW-1:0] entry_cmp;

  // shared compare: exact for search, case folded for the duplicate check
  assign key_cmp   = fold_i ? fold_case(key_i) : key_i;
  assign entry_cmp = fold_i ? fold_case(entry_i) : entry_i;
  assign hit_o     = (key_cmp == entry_cmp);

endmodule

/* src/keyed_fifo_with_search.sv */
// Keyed FIFO of DEPTH entries (name key, age) with enqueue, dequeue and search.
// An item is taken when start_i is high and busy_o is low; its result appears on
// status_o, out_name_o and out_age_o for exactly one cycle with result_valid_o
// high, and the receiver cannot stall it, so capture it in that cycle. Opcode 3
// is taken but gives no result. Full enqueue, empty dequeue and empty search
// answer in the cycle after they are taken; a dequeue reads the head entry in
// S_DEQ and then registers it as its result. Enqueue and search walk the stored
// entries oldest first through the single registered read port of the entry
// memory, one entry per cycle, and end the walk early on a search or duplicate
// hit. The next item may be started in the cycle its result is shown.
module keyed_fifo_with_search import kfs_pkg::*; #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned NAME_BYTES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       opcode_i,
  input  logic [NameW-1:0] entry_name_i,
  input  logic [AgeW-1:0]  entry_age_i,
  output logic             result_valid_o,
  output logic [2:0]       status_o,
  output logic [NameW-1:0] out_name_o,
  output logic [AgeW-1:0]  out_age_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DEQ  = 3'b100
  } state_e;

  // keep the top NAME_BYTES bytes up to the first zero byte
  function automatic logic [NameW-1:0] normalize(input logic [NameW-1:0] raw);
    logic [NameW-1:0] res;
    logic [ByteW-1:0] b;
    logic             alive;
    res   = '0;
    alive = 1'b1;
    for (int i = 0; i < NameCh; i++) begin
      b = raw[NameW-1-i*ByteW -: ByteW];
      if (alive && (i < NAME_BYTES) && (b != '0)) begin
        res[NameW-1-i*ByteW -: ByteW] = b;
      end else begin
        alive = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    return (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
  endfunction

  state_e           state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [AW-1:0]    tail_q, tail_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    slot_q, slot_d;
  logic [CW-1:0]    issued_q, issued_d;
  logic             pend_q, pend_d;
  opcode_e          op_q, op_d;
  logic [NameW-1:0] key_q, key_d;
  logic [AgeW-1:0]  age_q, age_d;

  logic             res_valid_q, res_valid_d;
  status_e          res_status_q, res_status_d;
  logic [NameW-1:0] res_name_q, res_name_d;
  logic [AgeW-1:0]  res_age_q, res_age_d;

  logic             mem_we;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [NameW-1:0] mem_rname;
  logic [AgeW-1:0]  mem_rage;
  logic             hit;
  logic             issue;
  opcode_e          op_in;

  assign op_in = opcode_e'(opcode_i);
  assign issue = (issued_q < count_q);

  kfs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wname_i (key_q),
    .wage_i  (age_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rname_o (mem_rname),
    .rage_o  (mem_rage)
  );

  kfs_match u_match (
    .key_i   (key_q),
    .entry_i (mem_rname),
    .fold_i  (op_q == OP_ENQUEUE),
    .hit_o   (hit)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    slot_d       = slot_q;
    issued_d     = issued_q;
    pend_d       = 1'b0;
    op_d         = op_q;
    key_d        = key_q;
    age_d        = age_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_name_d   = '0;
    res_age_d    = '0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = slot_q;

    unique case (state_q)
      S_IDLE: begin
        mem_raddr = head_q;
        if (start_i) begin
          op_d     = op_in;
          key_d    = normalize(entry_name_i);
          age_d    = entry_age_i;
          slot_d   = head_q;
          issued_d = '0;
          unique case (op_in)
            OP_ENQUEUE: begin
              if (count_q == CW'(DEPTH)) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_FULL;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_DEQUEUE: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_EMPTY;
              end else begin
                mem_re  = 1'b1;
                state_d = S_DEQ;
              end
            end
            OP_SEARCH: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_NOTFOUND;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_DEQ: begin
        res_valid_d  = 1'b1;
        res_status_d = ST_REMOVED;
        res_name_d   = mem_rname;
        res_age_d    = mem_rage;
        head_d       = next_slot(head_q);
        count_d      = count_q - CW'(1);
        state_d      = S_IDLE;
      end

      S_SCAN: begin
        // one read issued and one entry compared per cycle
        if (issue) begin
          mem_re   = 1'b1;
          slot_d   = next_slot(slot_q);
          issued_d = issued_q + CW'(1);
          pend_d   = 1'b1;
        end
        priority if (pend_q && hit) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (op_q == OP_ENQUEUE) begin
            res_status_d = ST_DUP;
          end else begin
            res_status_d = ST_FOUND;
            res_name_d   = mem_rname;
            res_age_d    = mem_rage;
          end
        end else if (!issue && (pend_q || count_q == '0)) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (op_q == OP_ENQUEUE) begin
            res_status_d = ST_ADDED;
            mem_we       = 1'b1;
            tail_d       = next_slot(tail_q);
            count_d      = count_q + CW'(1);
          end else begin
            res_status_d = ST_NOTFOUND;
          end
        end else begin
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      issued_q    <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      issued_q    <= issued_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    slot_q       <= slot_d;
    op_q         <= op_d;
    key_q        <= key_d;
    age_q        <= age_d;
    res_status_q <= res_status_d;
    res_name_q   <= res_name_d;
    res_age_q    <= res_age_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign out_name_o     = res_name_q;
  assign out_age_o      = res_age_q;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top import kfs_pkg::*;;

  localparam int Depth         = 64;
  localparam int NameBytes     = 8;
  localparam int TotalOps      = 1550;
  localparam int QuietTail     = 100;
  localparam int DrainCycles   = Depth + 16;
  localparam int WatchdogLimit = 2000;

  typedef struct {
    opcode_e          op;
    logic [NameW-1:0] name;
    logic [AgeW-1:0]  age;
  } fifo_op_t;

  typedef struct {
    status_e          status;
    logic [NameW-1:0] name;
    logic [AgeW-1:0]  age;
  } fifo_reply_t;

  // dut ports
  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             start_i        = 1'b0;
  logic [1:0]       opcode_i       = '0;
  logic [NameW-1:0] entry_name_i   = '0;
  logic [AgeW-1:0]  entry_age_i    = '0;
  logic             busy_o;
  logic             result_valid_o;
  logic [2:0]       status_o;
  logic [NameW-1:0] out_name_o;
  logic [AgeW-1:0]  out_age_o;

  // stimulus, predicted replies, bookkeeping
  fifo_op_t         ops_to_send[$];
  fifo_reply_t      replies_due[$];
  logic [NameW-1:0] recent_names[$];
  fifo_op_t         next_op;
  int               idle_left     = 0;
  int               idle_pct      = 10;
  int               quiet_cycles  = 0;
  int               mismatch_count = 0;

  // shadow copy of the queue contents
  logic [NameW-1:0] name_mem[Depth];
  logic [AgeW-1:0]  age_mem[Depth];
  int               head_idx   = 0;
  int               tail_idx   = 0;
  int               fill_count = 0;

  keyed_fifo_with_search #(
    .DEPTH     (Depth),
    .NAME_BYTES(NameBytes)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .entry_name_i  (entry_name_i),
    .entry_age_i   (entry_age_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .out_name_o    (out_name_o),
    .out_age_o     (out_age_o)
  );

  // clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // name handling: cut at first zero byte, fold upper case letters
  function automatic logic [NameW-1:0] norm_name(input logic [NameW-1:0] raw);
    logic ended;
    int   b;
    norm_name = '0;
    ended = 1'b0;
    for (b = 0; b < NameBytes; b++) begin
      if (raw[NameW-1-ByteW*b -: ByteW] == 8'h00) ended = 1'b1;
      if (!ended) norm_name[NameW-1-ByteW*b -: ByteW] = raw[NameW-1-ByteW*b -: ByteW];
    end
  endfunction

  function automatic logic [NameW-1:0] fold_lower(input logic [NameW-1:0] v);
    logic [ByteW-1:0] ch;
    int               b;
    fold_lower = v;
    for (b = 0; b < NameCh; b++) begin
      ch = v[ByteW*b +: ByteW];
      if (ch >= 8'h41 && ch <= 8'h5A) fold_lower[ByteW*b +: ByteW] = ch + 8'h20;
    end
  endfunction

  function automatic int next_slot(input int i);
    return (i + 1 >= Depth) ? 0 : i + 1;
  endfunction

  // apply one accepted item to the shadow queue and queue up its reply
  task automatic fifo_model_apply(input opcode_e op, input logic [NameW-1:0] raw,
                                  input logic [AgeW-1:0] age);
    fifo_reply_t      res;
    logic [NameW-1:0] key;
    int               slot;
    int               i;
    bit               hit;
    key = norm_name(raw);
    res.status = ST_NOTFOUND;
    res.name = '0;
    res.age = '0;
    hit = 1'b0;
    slot = head_idx;
    case (op)
      OP_ENQUEUE: begin
        if (fill_count >= Depth) begin
          res.status = ST_FULL;
        end else begin
          for (i = 0; i < fill_count && !hit; i++) begin
            if (fold_lower(name_mem[slot]) == fold_lower(key)) hit = 1'b1;
            slot = next_slot(slot);
          end
          if (hit) begin
            res.status = ST_DUP;
          end else begin
            name_mem[tail_idx] = key;
            age_mem[tail_idx] = age;
            tail_idx = next_slot(tail_idx);
            fill_count++;
            res.status = ST_ADDED;
          end
        end
      end
      OP_DEQUEUE: begin
        if (fill_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_REMOVED;
          res.name = name_mem[head_idx];
          res.age = age_mem[head_idx];
          head_idx = next_slot(head_idx);
          fill_count--;
        end
      end
      OP_SEARCH: begin
        for (i = 0; i < fill_count && !hit; i++) begin
          if (name_mem[slot] == key) begin
            hit = 1'b1;
            res.status = ST_FOUND;
            res.name = name_mem[slot];
            res.age = age_mem[slot];
          end
          slot = next_slot(slot);
        end
      end
      default: return;
    endcase
    replies_due.push_back(res);
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // stimulus helpers
  task automatic add_op(input opcode_e op, input logic [NameW-1:0] name,
                        input logic [AgeW-1:0] age);
    fifo_op_t o;
    o.op = op;
    o.name = name;
    o.age = age;
    ops_to_send.push_back(o);
    if (op == OP_ENQUEUE) begin
      recent_names.push_back(name);
      if (recent_names.size() > 96) void'(recent_names.pop_front());
    end
  endtask

  function automatic logic [NameW-1:0] letter_name();
    int               len;
    int               b;
    logic [ByteW-1:0] base;
    letter_name = '0;
    len = $urandom_range(1, NameCh);
    for (b = 0; b < len; b++) begin
      base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
      if (len <= 2)
        letter_name[NameW-1-ByteW*b -: ByteW] = base + 8'($urandom_range(0, 1));
      else
        letter_name[NameW-1-ByteW*b -: ByteW] = base + 8'($urandom_range(0, 25));
    end
  endfunction

  function automatic logic [NameW-1:0] fresh_name();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return letter_name();
    return {$urandom, $urandom};
  endfunction

  // pick a recently enqueued name, optionally with letter case swapped
  function automatic logic [NameW-1:0] recall_name(input bit flip);
    logic [NameW-1:0] v;
    logic [ByteW-1:0] ch;
    int               b;
    if (recent_names.size() == 0) return letter_name();
    v = recent_names[$urandom_range(0, recent_names.size() - 1)];
    if (flip) begin
      for (b = 0; b < NameCh; b++) begin
        ch = v[ByteW*b +: ByteW];
        if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A))
          v[ByteW*b +: ByteW] = ch ^ 8'h20;
      end
    end
    return v;
  endfunction

  // stimulus and end of run
  initial begin
    int n;
    int r;
    // directed: empty queue, case folding edges, name cut, unused opcode
    add_op(OP_DEQUEUE, '0, '0);
    add_op(OP_SEARCH, 64'h416C_6963_6500_0000, 8'h11);
    add_op(OP_NONE, 64'hDEAD_BEEF_0123_4567, 8'hA5);
    add_op(OP_ENQUEUE, 64'h416C_6963_6500_0000, 8'h00);
    add_op(OP_ENQUEUE, 64'h414C_4943_4500_0000, 8'h09);
    add_op(OP_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    add_op(OP_ENQUEUE, 64'h426F_0078_797A_4142, 8'h33);
    add_op(OP_SEARCH, 64'h426F_0000_0000_0000, 8'h00);
    add_op(OP_SEARCH, 64'h426F_00FF_FFFF_FFFF, 8'hFF);
    add_op(OP_SEARCH, 64'h616C_6963_6500_0000, 8'h00);
    add_op(OP_SEARCH, 64'h416C_6963_6500_0000, 8'h00);
    add_op(OP_ENQUEUE, 64'h0000_0000_0000_0000, 8'h5A);
    add_op(OP_ENQUEUE, 64'h00FF_FFFF_FFFF_FFFF, 8'h01);
    add_op(OP_SEARCH, 64'h0000_0000_0000_0000, 8'h00);
    add_op(OP_ENQUEUE, 64'hC100_0000_0000_0000, 8'h02);
    add_op(OP_ENQUEUE, 64'hE100_0000_0000_0000, 8'h03);
    add_op(OP_ENQUEUE, 64'h405B_0000_0000_0000, 8'h04);
    add_op(OP_ENQUEUE, 64'h607B_0000_0000_0000, 8'h05);
    add_op(OP_ENQUEUE, 64'h5A00_0000_0000_0000, 8'h06);
    add_op(OP_ENQUEUE, 64'h7A00_0000_0000_0000, 8'h07);
    add_op(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    add_op(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    repeat (4) add_op(OP_DEQUEUE, {$urandom, $urandom}, 8'($urandom));

    // random episodes: fill to full, drain to empty, or mixed traffic
    while (ops_to_send.size() < TotalOps) begin
      case ($urandom_range(0, 2))
        0: begin
          n = $urandom_range(60, 80);
          repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 80)      add_op(OP_ENQUEUE, fresh_name(), 8'($urandom));
            else if (r < 88) add_op(OP_ENQUEUE, recall_name(1'($urandom_range(0, 1))),
                                    8'($urandom));
            else if (r < 98) add_op(OP_SEARCH, recall_name(1'b0), 8'($urandom));
            else             add_op(OP_NONE, {$urandom, $urandom}, 8'($urandom));
          end
          // likely full now: duplicate names must still report full
          repeat (3) add_op(OP_ENQUEUE, recall_name(1'b0), 8'($urandom));
        end
        1: begin
          n = $urandom_range(55, 80);
          repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 75)      add_op(OP_DEQUEUE, {$urandom, $urandom}, 8'($urandom));
            else if (r < 95) add_op(OP_SEARCH, recall_name($urandom_range(0, 3) == 0),
                                    8'($urandom));
            else             add_op(OP_SEARCH, fresh_name(), 8'($urandom));
          end
        end
        default: begin
          n = $urandom_range(20, 40);
          repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 30)      add_op(OP_ENQUEUE, fresh_name(), 8'($urandom));
            else if (r < 40) add_op(OP_ENQUEUE, recall_name(1'($urandom_range(0, 1))),
                                    8'($urandom));
            else if (r < 65) add_op(OP_DEQUEUE, {$urandom, $urandom}, 8'($urandom));
            else if (r < 95) add_op(OP_SEARCH, recall_name($urandom_range(0, 3) == 0),
                                    8'($urandom));
            else             add_op(OP_NONE, {$urandom, $urandom}, 8'($urandom));
          end
        end
      endcase
    end

    // wait for all items taken and all replies seen, then let the block settle
    @(posedge rst_ni);
    while (ops_to_send.size() != 0 || start_i) @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && replies_due.size() == 0) begin
      $display("PASS keyed_fifo_with_search");
    end else begin
      $display("FAIL keyed_fifo_with_search");
    end
    $finish;
  end

  // driver: present items from the pending queue with random idle bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        fifo_model_apply(opcode_e'(opcode_i), entry_name_i, entry_age_i);
      end
      if (!start_i || !busy_o) begin
        if (idle_left == 0 && ops_to_send.size() > QuietTail &&
            $urandom_range(0, 99) < idle_pct) begin
          idle_left = $urandom_range(1, 7);
        end
        if (idle_left > 0 || ops_to_send.size() == 0) begin
          if (idle_left > 0) idle_left--;
          start_i      <= 1'b0;
          opcode_i     <= 2'($urandom);
          entry_name_i <= {$urandom, $urandom};
          entry_age_i  <= 8'($urandom);
        end else begin
          next_op = ops_to_send.pop_front();
          start_i      <= 1'b1;
          opcode_i     <= next_op.op;
          entry_name_i <= next_op.name;
          entry_age_i  <= next_op.age;
          // change idle density now and then, including stretches with none
          if ($urandom_range(0, 49) == 0) begin
            case ($urandom_range(0, 2))
              0:       idle_pct = 0;
              1:       idle_pct = 10;
              default: idle_pct = 35;
            endcase
          end
        end
      end
    end
  end

  // monitor: compare each reply with the oldest prediction
  always @(posedge clk_i) begin
    fifo_reply_t exp_reply;
    if (rst_ni && result_valid_o) begin
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("reply with no item pending, status %0d", status_o));
      end else begin
        exp_reply = replies_due.pop_front();
        if (status_o !== exp_reply.status)
          report_mismatch($sformatf("status got %0d exp %0d", status_o, exp_reply.status));
        if (out_name_o !== exp_reply.name)
          report_mismatch($sformatf("name got %h exp %h", out_name_o, exp_reply.name));
        if (out_age_o !== exp_reply.age)
          report_mismatch($sformatf("age got %h exp %h", out_age_o, exp_reply.age));
      end
    end
  end

  // watchdog: too long with no item taken and no reply
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL keyed_fifo_with_search");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* filelist.f */
src/kfs_pkg.sv
src/kfs_store.sv
src/kfs_match.sv
src/keyed_fifo_with_search.sv
sim/tb_top.sv
